FILE: rtl/core/scti_pkg.sv
// Package: shared constants and the half-wave sine sample generator.
`timescale 1ns / 1ps
`default_nettype none

package scti_pkg;

  // Fixed field widths
  localparam int unsigned PHASE_W = 24;
  localparam int unsigned REQ_W   = 1;

  // Default build configuration
  localparam int unsigned TABLE_ENTRIES_DEF     = 1024;
  localparam int unsigned FRACTION_BITS_DEF     = 13;
  localparam int unsigned OUTPUT_SCALE_BITS_DEF = 15;

  // Request kinds carried in tuser
  typedef enum logic [REQ_W-1:0] {
    REQ_SINE   = 1'b0,
    REQ_COSINE = 1'b1
  } req_type_e;

  // Quarter turn of the phase circle
  localparam logic [PHASE_W-1:0] QUARTER_TURN = PHASE_W'(1) << (PHASE_W - 2);

  // pi in unsigned Q62
  localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;

  // (a * b) >> 62, truncated to 64 bits
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // Unsigned 64-bit quotient by restoring long division; elaboration only
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // round(sin(i*pi/2^lg) * 2^osb), Taylor series in Q62; used at elaboration only
  function automatic logic [63:0] sine_sample(input int unsigned i, input int unsigned lg,
                                              input int unsigned osb);
    logic [63:0] n;
    logic [63:0] ii;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] dv;
    n  = 64'd1 << lg;
    ii = 64'(i);
    if ((ii << 1) > n) begin
      ii = n - ii;
    end
    q    = PI_Q62 >> lg;
    r    = PI_Q62 & (n - 64'd1);
    x    = q * ii + ((r * ii) >> lg);
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (int k = 1; k <= 16; k++) begin
      dv   = 64'((2 * k) * (2 * k + 1));
      term = div_u64(mul_q62(term, x2), dv);
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return (sum + (64'd1 << (61 - osb))) >> (62 - osb);
  endfunction

endpackage : scti_pkg

`default_nettype wire

FILE: rtl/core/scti_mem.sv
// Generic read-only memory: preloaded image, two read ports, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module scti_mem #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  parameter logic [DEPTH*WIDTH-1:0] INIT = '0,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [AW-1:0]    addr0_i,
  input  wire logic [AW-1:0]    addr1_i,
  output logic      [WIDTH-1:0] rdata0_o,
  output logic      [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] rdata0_q;
  logic [WIDTH-1:0] rdata1_q;

  // Registered reads, held while disabled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata0_q <= INIT[addr0_i*WIDTH +: WIDTH];
      rdata1_q <= INIT[addr1_i*WIDTH +: WIDTH];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule : scti_mem

`default_nettype wire

FILE: rtl/core/sine_cosine_table_interpolator_top.sv
// Top level: interpolated sine/cosine lookup from a half-wave sample table.
//
//  channel   | dir | tdata                         | tuser
//  s_axis    | in  | [23:0] phase                  | [0] req_type (0 sine, 1 cosine)
//  m_axis    | out | [VW-1:0] value (signed, 2^OSB = 1.0), zero fill | -
//
// One word per cycle sustained while the output is not stalled; table read, multiply and round/add are each registered.
// Throughput is set by the table memory's two read ports, which fetch both samples at once.
// Reset clears the stage valid flags; the table is a preloaded image and needs no fill.
// A stalled output freezes every stage, so s_axis_tready_o follows the output register.
`timescale 1ns / 1ps
`default_nettype none

module sine_cosine_table_interpolator_top
  import scti_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES     = TABLE_ENTRIES_DEF,
  parameter int unsigned FRACTION_BITS     = FRACTION_BITS_DEF,
  parameter int unsigned OUTPUT_SCALE_BITS = OUTPUT_SCALE_BITS_DEF,
  localparam int unsigned VW      = OUTPUT_SCALE_BITS + 2,
  localparam int unsigned OUT_TDW = ((VW + 7) / 8) * 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [PHASE_W-1:0] s_axis_tdata_i,   // [23:0] phase
  input  wire logic [REQ_W-1:0]   s_axis_tuser_i,   // [0] req_type
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output logic [OUT_TDW-1:0]      m_axis_tdata_o    // [VW-1:0] value, zeros above
);

  localparam int unsigned AW     = $clog2(TABLE_ENTRIES);
  localparam int unsigned IDX_W  = AW + 1;
  localparam int unsigned RW     = OUTPUT_SCALE_BITS + 1;
  localparam int unsigned DIFF_W = VW + 1;
  localparam int unsigned PROD_W = DIFF_W + FRACTION_BITS + 1;

  // Build the half-wave table image at elaboration
  function automatic logic [TABLE_ENTRIES*RW-1:0] build_image();
    logic [TABLE_ENTRIES*RW-1:0] img;
    logic [63:0]                 smp;
    img = '0;
    for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
      smp = sine_sample(i, AW, OUTPUT_SCALE_BITS);
      img[i*RW +: RW] = smp[RW-1:0];
    end
    return img;
  endfunction

  localparam logic [TABLE_ENTRIES*RW-1:0] ROM_IMAGE = build_image();

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRACTION_BITS - 1);

  // Pipeline advance: everything moves unless the output word is stuck
  logic adv;
  logic s_fire;

  // Stage 0: phase, indices, fraction
  logic [PHASE_W-1:0]       ph;
  logic [PHASE_W-1:0]       ph_idx;
  logic [IDX_W-1:0]         idx0;
  logic [IDX_W-1:0]         idx1;

  // Stage 1: table data plus sideband
  logic                     v1_q;
  logic                     sgn0_q;
  logic                     sgn1_q;
  logic [FRACTION_BITS-1:0] frac_q;
  logic [RW-1:0]            rom0;
  logic [RW-1:0]            rom1;
  logic signed [VW-1:0]     a_s1;
  logic signed [VW-1:0]     b_s1;
  logic signed [DIFF_W-1:0] diff;
  logic signed [FRACTION_BITS:0] frac_s;
  logic signed [PROD_W-1:0] prod_d;

  // Stage 2: base sample and weighted difference
  logic                     v2_q;
  logic signed [VW-1:0]     a_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] shf;
  logic [VW-1:0]            value_d;

  // Stage 3: output register
  logic                     v3_q;
  logic [VW-1:0]            value_q;

  assign adv             = !v3_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign s_fire          = s_axis_tvalid_i && adv;

  // Cosine shifts the phase by a quarter turn; wraps modulo a full turn
  always_comb begin
    ph = s_axis_tdata_i;
    if (req_type_e'(s_axis_tuser_i) == REQ_COSINE) begin
      ph = s_axis_tdata_i + QUARTER_TURN;
    end
    ph_idx = ph >> FRACTION_BITS;
    idx0   = ph_idx[IDX_W-1:0];
    idx1   = idx0 + IDX_W'(1);
  end

  scti_mem #(
    .WIDTH (RW),
    .DEPTH (TABLE_ENTRIES),
    .INIT  (ROM_IMAGE)
  ) u_table (
    .clk_i    (clk_i),
    .en_i     (adv),
    .addr0_i  (idx0[AW-1:0]),
    .addr1_i  (idx1[AW-1:0]),
    .rdata0_o (rom0),
    .rdata1_o (rom1)
  );

  // Sideband aligned with the table read
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sgn0_q <= idx0[IDX_W-1];
      sgn1_q <= idx1[IDX_W-1];
      frac_q <= ph[FRACTION_BITS-1:0];
    end
  end

  // Second half of the wave reads negated samples; weight the difference
  always_comb begin
    a_s1   = sgn0_q ? -$signed({1'b0, rom0}) : $signed({1'b0, rom0});
    b_s1   = sgn1_q ? -$signed({1'b0, rom1}) : $signed({1'b0, rom1});
    diff   = DIFF_W'(b_s1) - DIFF_W'(a_s1);
    frac_s = $signed({1'b0, frac_q});
    prod_d = PROD_W'(diff) * PROD_W'(frac_s);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q    <= a_s1;
      prod_q <= prod_d;
    end
  end

  // Round to nearest (ties up) and add the base sample
  always_comb begin
    rnd     = prod_q + ROUND_HALF;
    shf     = rnd >>> FRACTION_BITS;
    value_d = VW'(a_q + shf[VW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      value_q <= value_d;
    end
  end

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_fire;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = OUT_TDW'(value_q);

`ifndef SYNTHESIS
  // An accepted word reaches stage 1
  a_fire_to_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> v1_q)
    else $error("accepted word lost before stage 1");

  // A stalled output holds the stages behind it
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !m_axis_tready_i) |=> ($stable(v2_q) && $stable(v1_q) && $stable(value_q)))
    else $error("pipeline moved during output stall");

  // Result stays within plus/minus full scale
  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (($signed(value_q) <= $signed((VW+1)'(1) << OUTPUT_SCALE_BITS)) &&
              ($signed(value_q) >= -$signed((VW+1)'(1) << OUTPUT_SCALE_BITS))))
    else $error("interpolated value out of range");
`endif

endmodule : sine_cosine_table_interpolator_top

`default_nettype wire

FILE: bench/sine_cosine_table_interpolator_top_tb.sv
// Testbench: stream-driven self-checking bench for the sine/cosine table interpolator.
`timescale 1ns / 1ps
`default_nettype none

module sine_cosine_table_interpolator_top_tb
  import scti_pkg::*;
();

  localparam int unsigned HALF_N     = 1024;
  localparam int unsigned FRAC_W     = 13;
  localparam int unsigned SCALE_W    = 15;
  localparam int unsigned VAL_W      = SCALE_W + 2;
  localparam int unsigned OUT_W      = ((VAL_W + 7) / 8) * 8;
  localparam int unsigned N_RANDOM   = 1430;
  localparam int unsigned N_ROWS     = 20;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int unsigned DRAIN_WAIT = 10;
  // pi in unsigned Q62
  localparam logic [63:0] PI_FIXED   = 64'hC90F_DAA2_2168_C235;

  // One directed row; known marks a hand-typed result
  typedef struct packed {
    req_type_e          req;
    logic [23:0]        phase;
    logic               known;
    logic signed [16:0] value;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid_i;
  logic s_axis_tready_o;
  logic [PHASE_W-1:0] s_axis_tdata_i;   // [23:0] phase
  logic [REQ_W-1:0] s_axis_tuser_i;     // [0] req_type
  logic m_axis_tvalid_o;
  logic m_axis_tready_i;
  logic [OUT_W-1:0] m_axis_tdata_o;     // [16:0] value, zeros above

  // Side-band for hand-typed results, driven along with each word
  logic               typed_known;
  logic signed [16:0] typed_value;

  // Stretch with no idling on either side
  logic calm;

  int              sine_half [HALF_N];
  logic [16:0]     amplitude_q [$];
  int unsigned     err_count;
  int unsigned     cycle_count;
  stim_row_t       dir_rows [N_ROWS];

  sine_cosine_table_interpolator_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Q62 fixed-point product, keeping bits 125..62
  function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Half-wave sample: round(sin(i*pi/HALF_N) * 2^SCALE_W) via Taylor series in Q62
  function automatic int half_sine_sample(input int unsigned i);
    logic [63:0] n;
    logic [63:0] k_i;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] dv;
    n   = 64'(HALF_N);
    k_i = 64'(i);
    if (2 * k_i > n) begin
      k_i = n - k_i;
    end
    x    = (PI_FIXED / n) * k_i + ((PI_FIXED % n) * k_i) / n;
    x2   = q62_product(x, x);
    term = x;
    acc  = x;
    for (int k = 1; k <= 16; k++) begin
      dv   = 64'((2 * k) * (2 * k + 1));
      term = q62_product(term, x2) / dv;
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return int'((acc + (64'd1 << (61 - SCALE_W))) >> (62 - SCALE_W));
  endfunction

  // Full-wave sample: upper half is the negated half-wave
  function automatic longint full_wave(input int unsigned k);
    if (k >= HALF_N) begin
      return -longint'(sine_half[k - HALF_N]);
    end
    return longint'(sine_half[k]);
  endfunction

  // Interpolated amplitude for one request
  function automatic logic [16:0] amplitude(input req_type_e req, input logic [23:0] ph);
    logic [23:0]  p;
    int unsigned  idx0;
    int unsigned  idx1;
    longint       frac;
    longint       a;
    longint       b;
    longint       t;
    p = ph;
    if (req == REQ_COSINE) begin
      p = p + QUARTER_TURN;
    end
    idx0 = int'(p >> FRAC_W) % (2 * HALF_N);
    idx1 = (idx0 + 1) % (2 * HALF_N);
    frac = longint'(p & ((24'd1 << FRAC_W) - 24'd1));
    a    = full_wave(idx0);
    b    = full_wave(idx1);
    t    = (b - a) * frac + (64'sd1 <<< (FRAC_W - 1));
    return 17'(a + (t >>> FRAC_W));
  endfunction

  // One line per mismatch, counted
  task automatic report_mismatch(input string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Drive one word, idling at random first; returns at the accepting edge
  task automatic put_word(input req_type_e req, input logic [23:0] ph, input logic known,
                          input logic signed [16:0] val);
    while (!calm && $urandom_range(99) < 33) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= ph;
    s_axis_tuser_i  <= req;
    typed_known     <= known;
    typed_value     <= val;
    @(posedge clk_i);
    while (!s_axis_tready_o) begin
      @(posedge clk_i);
    end
  endtask

  // Hold off the sender until every pending result has come back
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (amplitude_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Random phase: mostly full range, with stress near quadrants, fraction extremes and wrap
  function automatic logic [23:0] pick_phase();
    logic [23:0] p;
    case ($urandom_range(4)) inside
      [0:1]: p = 24'($urandom);
      2: p = {2'($urandom_range(3)), 22'd0} + 24'($urandom_range(64)) - 24'd32;
      3: begin
        p = {11'($urandom), 13'd0};
        case ($urandom_range(3))
          0: p[12:0] = 13'h0000;
          1: p[12:0] = 13'h1FFF;
          2: p[12:0] = 13'h1000;
          default: p[12:0] = 13'h0FFF;
        endcase
      end
      default: p = 24'hFFFFFF - 24'($urandom_range(16383));
    endcase
    return p;
  endfunction

  // Output side backpressure
  always @(posedge clk_i) begin
    if (calm) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= 33);
    end
  end

  // Scoreboard: queue an expectation per accepted word, check each result word
  always @(posedge clk_i) begin
    logic [16:0] want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        if (typed_known) begin
          amplitude_q.push_back(typed_value);
        end else begin
          amplitude_q.push_back(amplitude(req_type_e'(s_axis_tuser_i), s_axis_tdata_i));
        end
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (amplitude_q.size() == 0) begin
          report_mismatch($sformatf("result word 0x%06h with nothing pending", m_axis_tdata_o));
        end else begin
          want = amplitude_q.pop_front();
          if (m_axis_tdata_o !== OUT_W'(want)) begin
            report_mismatch($sformatf("value got 0x%06h want 0x%06h (%0d)",
                                      m_axis_tdata_o, OUT_W'(want), $signed(want)));
          end
        end
      end
    end
  end

  // Run-length guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("sine_cosine_table_interpolator_top_tb: FAIL");
      $finish;
    end
  end

  // Stimulus
  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = REQ_SINE;
    m_axis_tready_i = 1'b0;
    typed_known     = 1'b0;
    typed_value     = '0;
    calm            = 1'b0;
    err_count       = 0;
    cycle_count     = 0;

    for (int i = 0; i < HALF_N; i++) begin
      sine_half[i] = half_sine_sample(i);
    end

    // Quadrant points have known results; the rest go through the predictor
    dir_rows[0]  = '{REQ_SINE,   24'h000000, 1'b1, 17'sd0};
    dir_rows[1]  = '{REQ_COSINE, 24'h000000, 1'b1, 17'sd32768};
    dir_rows[2]  = '{REQ_SINE,   24'h400000, 1'b1, 17'sd32768};
    dir_rows[3]  = '{REQ_SINE,   24'h800000, 1'b1, 17'sd0};
    dir_rows[4]  = '{REQ_SINE,   24'hC00000, 1'b1, -17'sd32768};
    dir_rows[5]  = '{REQ_COSINE, 24'h400000, 1'b1, 17'sd0};
    dir_rows[6]  = '{REQ_COSINE, 24'h800000, 1'b1, -17'sd32768};
    dir_rows[7]  = '{REQ_COSINE, 24'hC00000, 1'b1, 17'sd0};       // phase wraps to zero
    dir_rows[8]  = '{REQ_SINE,   24'hFFFFFF, 1'b0, 17'sd0};       // last sample to first
    dir_rows[9]  = '{REQ_COSINE, 24'hBFFFFF, 1'b0, 17'sd0};       // cosine wrap edge
    dir_rows[10] = '{REQ_COSINE, 24'hFFFFFF, 1'b0, 17'sd0};
    dir_rows[11] = '{REQ_SINE,   24'h001000, 1'b0, 17'sd0};       // half-way fraction
    dir_rows[12] = '{REQ_SINE,   24'h7FFFFF, 1'b0, 17'sd0};
    dir_rows[13] = '{REQ_SINE,   24'h3FFFFF, 1'b0, 17'sd0};
    dir_rows[14] = '{REQ_SINE,   24'h801FFF, 1'b0, 17'sd0};
    dir_rows[15] = '{REQ_SINE,   24'hAAAAAA, 1'b0, 17'sd0};
    dir_rows[16] = '{REQ_COSINE, 24'h555555, 1'b0, 17'sd0};
    dir_rows[17] = '{REQ_SINE,   24'h000001, 1'b0, 17'sd0};
    dir_rows[18] = '{REQ_SINE,   24'h7FE000, 1'b0, 17'sd0};       // top entry of the half wave
    dir_rows[19] = '{REQ_COSINE, 24'h3FF000, 1'b0, 17'sd0};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows
    for (int r = 0; r < N_ROWS; r++) begin
      put_word(dir_rows[r].req, dir_rows[r].phase, dir_rows[r].known, dir_rows[r].value);
    end
    drain_results();

    // Random rows, with one quiet stretch and one mid-run drain
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 400) begin
        drain_results();
      end
      calm <= (n >= 700 && n < 1000);
      put_word(req_type_e'($urandom_range(1)), pick_phase(), 1'b0, 17'sd0);
    end
    s_axis_tvalid_i <= 1'b0;
    calm            <= 1'b0;

    // Let the scoreboard log the last accepted word before waiting on the queue
    @(posedge clk_i);
    while (amplitude_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (err_count == 0) begin
      $display("sine_cosine_table_interpolator_top_tb: PASS");
    end else begin
      $display("sine_cosine_table_interpolator_top_tb: FAIL");
    end
    $finish;
  end

endmodule : sine_cosine_table_interpolator_top_tb

`default_nettype wire
